// File: hw/rtl/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
// Used by every module under hw/rtl except dpb_fifo; depends on nothing.
package dpb_pkg;

    localparam int NUM_AXES = 3;
    localparam int CFG_IDX_W = 3;

    // Registered stages of one axis datapath, issue to result.
    localparam int AXIS_LAT = 7;

    // Rounded quotient (N + 128000) >>> 11 is clamped so that a division by
    // 125 lands inside the Q16.16 range; the offset makes it non-negative.
    localparam logic signed [52:0] Q1_MAX = 53'sd268435455999;
    localparam logic signed [52:0] Q1_MIN = -53'sd268435456000;
    localparam logic signed [52:0] Q1_OFS = 53'sd268435456000;
    localparam logic signed [63:0] ROUND_ADD = 64'sd128000;

    // ceil(2^30 / 125): exact quotient by 125 for any value below 2^23.
    localparam logic [23:0] RECIP_125 = 24'd8589935;
    localparam logic [6:0] DIV_125 = 7'd125;
    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_COL_ROW     = 3'd0,
        CFG_X_CONST_TRANS = 3'd1,
        CFG_Y_COL_ROW     = 3'd2,
        CFG_Y_CONST_TRANS = 3'd3,
        CFG_Z_COL_ROW     = 3'd4,
        CFG_Z_CONST_TRANS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic [15:0] depth_mm;
        logic [7:0]  in_blue;
        logic [7:0]  in_green;
        logic [7:0]  in_red;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
    } t_point;

    // Signed Q8.24 coefficients of one axis.
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] t;
    } t_axis_coef;

    typedef struct packed {
        logic drop;
        logic store;
    } t_front_stat;

    typedef struct packed {
        logic out_push;
        logic out_full;
    } t_back_stat;

endpackage

// File: hw/rtl/dpb_fifo.sv
// Small flop-based queue with show-ahead read.
// Standalone; used by dpb_front and dpb_back.
module dpb_fifo #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// File: hw/rtl/dpb_front.sv
// Front end: takes pixel words, drops zero-depth pixels, queues the rest.
// Depends on dpb_pkg and dpb_fifo.
module dpb_front #(
    parameter int unsigned MID_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dpb_pkg::t_pixel      i_pixel,
    output logic                 o_full,
    input  logic                 i_mid_pop,
    output dpb_pkg::t_pixel      o_mid_pixel,
    output logic                 o_mid_empty,
    output dpb_pkg::t_front_stat o_stat
);
    import dpb_pkg::*;

    logic   w_accept;
    logic   w_no_depth;
    logic   w_full;
    t_pixel w_rdata;

    assign w_accept     = i_push && !w_full;
    assign w_no_depth   = (i_pixel.depth_mm == '0);
    assign o_full       = w_full;
    assign o_stat.drop  = w_accept && w_no_depth;
    assign o_stat.store = w_accept && !w_no_depth;
    assign o_mid_pixel  = w_rdata;

    dpb_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(t_pixel))
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_stat.store),
        .i_wdata (i_pixel),
        .i_pop   (i_mid_pop),
        .o_rdata (w_rdata),
        .o_full  (w_full),
        .o_empty (o_mid_empty)
    );

endmodule

// File: hw/rtl/dpb_axis.sv
// One axis datapath: depth_mm * (a*col + b*row + c) + 1000*t, rounded,
// divided by 256000 and saturated to Q16.16. Depends on dpb_pkg.
module dpb_axis (
    input  logic                i_clk,
    input  dpb_pkg::t_axis_coef i_coef,
    input  logic [11:0]         i_col,
    input  logic [11:0]         i_row,
    input  logic [15:0]         i_depth,
    output logic signed [31:0]  o_coord
);
    import dpb_pkg::*;

    // stage 1
    logic signed [44:0] r_pc;
    logic signed [44:0] r_pr;
    logic signed [31:0] r_c;
    logic signed [41:0] r_t1k;
    logic [15:0]        r_d1;
    // stage 2
    logic signed [45:0] r_s;
    logic signed [41:0] r_t1k2;
    logic [15:0]        r_d2;
    // stage 3
    logic signed [62:0] r_prod;
    logic signed [41:0] r_t1k3;
    // stage 4
    logic signed [63:0] w_n;
    logic signed [52:0] w_q1;
    logic signed [52:0] w_q1c;
    logic signed [52:0] w_u;
    logic [38:0]        r_u;
    // stage 5
    logic [46:0]        r_hm;
    logic [22:0]        r_hi;
    logic [15:0]        r_lo;
    // stage 6
    logic [15:0]        w_qh;
    logic [22:0]        w_rh;
    logic [22:0]        r_r2;
    logic [15:0]        r_qh;
    // stage 7
    logic [46:0]        r_lm;
    logic [15:0]        r_qh2;

    always_ff @(posedge i_clk) begin
        r_pc  <= i_coef.a * $signed({1'b0, i_col});
        r_pr  <= i_coef.b * $signed({1'b0, i_row});
        r_c   <= i_coef.c;
        r_t1k <= i_coef.t * 42'sd1000;
        r_d1  <= i_depth;
    end

    always_ff @(posedge i_clk) begin
        r_s    <= 46'(r_pc) + 46'(r_pr) + 46'(r_c);
        r_t1k2 <= r_t1k;
        r_d2   <= r_d1;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_s * $signed({1'b0, r_d2});
        r_t1k3 <= r_t1k2;
    end

    // round, scale by 2^-11, clamp, then shift to non-negative
    always_comb begin
        w_n  = 64'(r_prod) + 64'(r_t1k3) + ROUND_ADD;
        w_q1 = w_n[63:11];
        if (w_q1 > Q1_MAX) begin
            w_q1c = Q1_MAX;
        end else if (w_q1 < Q1_MIN) begin
            w_q1c = Q1_MIN;
        end else begin
            w_q1c = w_q1;
        end
        w_u = w_q1c + Q1_OFS;
    end

    always_ff @(posedge i_clk) begin
        r_u <= w_u[38:0];
    end

    // divide by 125 in two halves: high 23 bits first, remainder joins low
    always_ff @(posedge i_clk) begin
        r_hm <= 47'(r_u[38:16]) * 47'(RECIP_125);
        r_hi <= r_u[38:16];
        r_lo <= r_u[15:0];
    end

    assign w_qh = r_hm[45:30];
    assign w_rh = r_hi - 23'(w_qh) * 23'(DIV_125);

    always_ff @(posedge i_clk) begin
        r_r2 <= {w_rh[6:0], r_lo};
        r_qh <= w_qh;
    end

    always_ff @(posedge i_clk) begin
        r_lm  <= 47'(r_r2) * 47'(RECIP_125);
        r_qh2 <= r_qh;
    end

    // undo the offset of 2^31 by flipping the sign bit
    assign o_coord = $signed({r_qh2, r_lm[45:30]} ^ SIGN_FLIP);

endmodule

// File: hw/rtl/dpb_back.sv
// Back end: issues queued pixels into the three axis datapaths against
// credits for the result queue. Depends on dpb_pkg, dpb_axis, dpb_fifo.
module dpb_back #(
    parameter int unsigned OUT_DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  dpb_pkg::t_axis_coef [dpb_pkg::NUM_AXES-1:0] i_coef,
    input  dpb_pkg::t_pixel                             i_mid_pixel,
    input  logic                                        i_mid_empty,
    output logic                                        o_mid_pop,
    output dpb_pkg::t_point                             o_point,
    output logic                                        o_empty,
    input  logic                                        i_pop,
    output dpb_pkg::t_back_stat                         o_stat
);
    import dpb_pkg::*;

    localparam int CRW = $clog2(OUT_DEPTH + 1);

    logic                 w_issue;
    logic                 w_take;
    logic                 w_out_full;
    logic [CRW-1:0]       r_credit;
    logic [CRW-1:0]       n_credit;
    logic [AXIS_LAT-1:0]  r_vld;
    logic [23:0]          r_rgb [AXIS_LAT];
    logic signed [31:0]   w_coord [NUM_AXES];
    t_point               w_point;

    // credit = result slots not yet claimed by a pixel in flight
    assign w_issue   = !i_mid_empty && (r_credit != '0);
    assign w_take    = i_pop && !o_empty;
    assign o_mid_pop = w_issue;

    always_comb begin
        n_credit = r_credit;
        if (w_issue && !w_take) begin
            n_credit = r_credit - 1'b1;
        end else if (w_take && !w_issue) begin
            n_credit = r_credit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CRW'(OUT_DEPTH);
            r_vld    <= '0;
        end else begin
            r_credit <= n_credit;
            r_vld    <= {r_vld[AXIS_LAT-2:0], w_issue};
        end
    end

    // colour rides alongside the axis pipes, reordered to RGB
    always_ff @(posedge i_clk) begin
        r_rgb[0] <= {i_mid_pixel.in_red, i_mid_pixel.in_green, i_mid_pixel.in_blue};
        for (int i = 1; i < AXIS_LAT; i++) begin
            r_rgb[i] <= r_rgb[i-1];
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        dpb_axis u_axis (
            .i_clk   (i_clk),
            .i_coef  (i_coef[g]),
            .i_col   (i_mid_pixel.pixel_col),
            .i_row   (i_mid_pixel.pixel_row),
            .i_depth (i_mid_pixel.depth_mm),
            .o_coord (w_coord[g])
        );
    end

    always_comb begin
        w_point.point_x   = w_coord[0];
        w_point.point_y   = w_coord[1];
        w_point.point_z   = w_coord[2];
        w_point.out_red   = r_rgb[AXIS_LAT-1][23:16];
        w_point.out_green = r_rgb[AXIS_LAT-1][15:8];
        w_point.out_blue  = r_rgb[AXIS_LAT-1][7:0];
    end

    assign o_stat.out_push = r_vld[AXIS_LAT-1];
    assign o_stat.out_full = w_out_full;

    dpb_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_point))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_vld[AXIS_LAT-1]),
        .i_wdata (w_point),
        .i_pop   (i_pop),
        .o_rdata (o_point),
        .o_full  (w_out_full),
        .o_empty (o_empty)
    );

endmodule

// File: hw/rtl/depth_pixel_backprojection.sv
// Depth pixel back-projection: depth pixel in, coloured 3-D point out.
// Depends on dpb_pkg, dpb_front, dpb_back (and through them dpb_axis, dpb_fifo).
//
// Input channel: drive i_pixel and push; a word is taken at a clock edge with
// push high and full low. Pixels with zero depth are taken and dropped.
// Result channel: while empty is low, o_point holds the oldest point; it is
// taken at an edge with pop high. Points leave in pixel order.
// Configuration: i_cfg_index / i_cfg_data written when i_cfg_valid is high
// (o_cfg_ready is always high). Indexes 0..5 select the x, y, z coefficient
// pairs; others are ignored. Write only while no pixel is in flight.
// Throughput: one pixel per cycle, sustained while pop keeps up, set by the fully
// pipelined axis datapaths. A taken pixel is written to the front queue, passes
// the seven datapath stages and is written to the result queue, then shows on o_point.
// Stall: the back end issues only against free result-queue slots; when pop
// stays low, the result queue, then the front queue fill and full rises.
// Reset: both queues empty, all coefficients zero.
module depth_pixel_backprojection #(
    parameter int unsigned MID_DEPTH = 4,
    parameter int unsigned OUT_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    input  dpb_pkg::t_pixel                 i_pixel,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output dpb_pkg::t_point                 o_point,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);
    import dpb_pkg::*;

    t_axis_coef [NUM_AXES-1:0] r_coef;
    t_pixel                    w_mid_pixel;
    logic                      w_mid_empty;
    logic                      w_mid_pop;
    logic                      w_cfg_wr;
    t_front_stat               w_front_st;
    t_back_stat                w_back_st;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (w_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X_COL_ROW: begin
                    r_coef[0].a <= i_cfg_data[63:32];
                    r_coef[0].b <= i_cfg_data[31:0];
                end
                CFG_X_CONST_TRANS: begin
                    r_coef[0].c <= i_cfg_data[63:32];
                    r_coef[0].t <= i_cfg_data[31:0];
                end
                CFG_Y_COL_ROW: begin
                    r_coef[1].a <= i_cfg_data[63:32];
                    r_coef[1].b <= i_cfg_data[31:0];
                end
                CFG_Y_CONST_TRANS: begin
                    r_coef[1].c <= i_cfg_data[63:32];
                    r_coef[1].t <= i_cfg_data[31:0];
                end
                CFG_Z_COL_ROW: begin
                    r_coef[2].a <= i_cfg_data[63:32];
                    r_coef[2].b <= i_cfg_data[31:0];
                end
                CFG_Z_CONST_TRANS: begin
                    r_coef[2].c <= i_cfg_data[63:32];
                    r_coef[2].t <= i_cfg_data[31:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    dpb_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .o_full      (full),
        .i_mid_pop   (w_mid_pop),
        .o_mid_pixel (w_mid_pixel),
        .o_mid_empty (w_mid_empty),
        .o_stat      (w_front_st)
    );

    dpb_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef      (r_coef),
        .i_mid_pixel (w_mid_pixel),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .o_point     (o_point),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_stat      (w_back_st)
    );

    // a zero-depth word never enters the front queue
    a_zero_depth_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_pixel.depth_mm == '0) |-> (w_front_st.drop && !w_front_st.store))
        else $error("zero-depth pixel stored");

    // credits must keep the result queue from overflowing
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_st.out_push |-> !w_back_st.out_full)
        else $error("result queue overflow");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

// File: dv/tb_depth_pixel_backprojection.sv
`timescale 1ns / 100ps
// Self-checking testbench for depth_pixel_backprojection: streams depth pixels
// and coefficient writes, predicts each point in place and checks popped words.
// Depends on dpb_pkg and the RTL under hw/rtl.
module tb_depth_pixel_backprojection;
    import dpb_pkg::*;

    localparam int NUM_REGS       = 6;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [31:0] COL_SPAN   = 32'h0002_0000;
    localparam logic [31:0] CONST_SPAN = 32'h0400_0000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {
        COEF_ZERO, COEF_CAMERA, COEF_RANDOM, COEF_MAX, COEF_MIN, COEF_ONES
    } t_coef_style;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    t_pixel               i_pixel;
    logic                 full;
    logic                 empty;
    logic                 pop;
    t_point               o_point;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    logic [63:0] coef_regs [NUM_REGS];
    t_point      pending_points [$];
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int          rx_hold = 0;

    depth_pixel_backprojection dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_pixel     (i_pixel),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_point     (o_point),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One axis: round((a*col + b*row + c) * depth + 1000*t) / 256000, ties up,
    // then clamp to Q16.16.
    function automatic logic [31:0] axis_coord(int axis, t_pixel px);
        logic signed [63:0] a, b, c, t, col, row, depth, num, q;
        a = $signed(coef_regs[2*axis][63:32]);
        b = $signed(coef_regs[2*axis][31:0]);
        c = $signed(coef_regs[2*axis+1][63:32]);
        t = $signed(coef_regs[2*axis+1][31:0]);
        col = {52'd0, px.pixel_col};
        row = {52'd0, px.pixel_row};
        depth = {48'd0, px.depth_mm};
        num = (a * col + b * row + c) * depth + 64'sd1000 * t + 64'sd128000;
        q = num / 64'sd256000;
        if ((num % 64'sd256000) != 64'sd0 && num < 64'sd0)
            q = q - 64'sd1;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        else if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic t_point project_pixel(t_pixel px);
        t_point pt;
        pt.point_x   = axis_coord(0, px);
        pt.point_y   = axis_coord(1, px);
        pt.point_z   = axis_coord(2, px);
        pt.out_red   = px.in_red;
        pt.out_green = px.in_green;
        pt.out_blue  = px.in_blue;
        return pt;
    endfunction

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 25);
    endfunction

    function automatic logic [31:0] coef_half(t_coef_style style, logic [31:0] span);
        logic [31:0] mag;
        case (style)
            COEF_ZERO: return 32'h0000_0000;
            COEF_MAX:  return 32'h7FFF_FFFF;
            COEF_MIN:  return 32'h8000_0000;
            COEF_ONES: return 32'hFFFF_FFFF;
            COEF_CAMERA: begin
                mag = $urandom_range(span);
                return ($urandom_range(1) != 0) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pixel mk_pixel(logic [11:0] col, logic [11:0] row,
                                        logic [15:0] depth, logic [7:0] blue,
                                        logic [7:0] green, logic [7:0] red);
        t_pixel px;
        px.pixel_col = col;
        px.pixel_row = row;
        px.depth_mm  = depth;
        px.in_blue   = blue;
        px.in_green  = green;
        px.in_red    = red;
        return px;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        int r;
        px = t_pixel'({$urandom, $urandom});
        r = $urandom_range(99);
        if (r < 8)
            px.depth_mm = 16'd0;
        else if (r < 20)
            px.depth_mm = 16'($urandom_range(15, 1));
        else if (r < 25)
            px.depth_mm = 16'hFFFF;
        r = $urandom_range(99);
        if (r < 5) begin
            px.pixel_col = 12'd0;
            px.pixel_row = 12'd0;
        end else if (r < 10) begin
            px.pixel_col = 12'hFFF;
            px.pixel_row = 12'hFFF;
        end
        return px;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    task automatic send_pixel(t_pixel px);
        int gap;
        @(negedge i_clk);
        push    <= 1'b1;
        i_pixel <= px;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        // zero depth is taken and dropped
        if (px.depth_mm != 16'd0)
            pending_points = {pending_points, project_pixel(px)};
        gap = tx_gaps_on ? rand_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_points();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
    endtask

    // Drain every expected point and let the bench idle on before touching registers.
    task automatic settle();
        drain_points();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        if (idx < NUM_REGS)
            coef_regs[idx] = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [63:0] x_cr, logic [63:0] x_ct, logic [63:0] y_cr,
                             logic [63:0] y_ct, logic [63:0] z_cr, logic [63:0] z_ct);
        settle();
        write_reg(CFG_X_COL_ROW, x_cr);
        write_reg(CFG_X_CONST_TRANS, x_ct);
        write_reg(CFG_Y_COL_ROW, y_cr);
        write_reg(CFG_Y_CONST_TRANS, y_ct);
        write_reg(CFG_Z_COL_ROW, z_cr);
        write_reg(CFG_Z_CONST_TRANS, z_ct);
    endtask

    task automatic load_coefs(t_coef_style style);
        write_all({coef_half(style, COL_SPAN), coef_half(style, COL_SPAN)},
                  {coef_half(style, CONST_SPAN), coef_half(style, CONST_SPAN)},
                  {coef_half(style, COL_SPAN), coef_half(style, COL_SPAN)},
                  {coef_half(style, CONST_SPAN), coef_half(style, CONST_SPAN)},
                  {coef_half(style, COL_SPAN), coef_half(style, COL_SPAN)},
                  {coef_half(style, CONST_SPAN), coef_half(style, CONST_SPAN)});
    endtask

    task automatic send_corners();
        send_pixel(mk_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00));
        send_pixel(mk_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(mk_pixel(12'hFFF, 12'd0, 16'd1000, 8'h12, 8'h34, 8'h56));
        send_pixel(mk_pixel(12'd0, 12'hFFF, 16'h8000, 8'hA5, 8'h5A, 8'hC3));
    endtask

    task automatic test_reset_defaults();
        send_pixel(mk_pixel(12'd320, 12'd240, 16'd1500, 8'h10, 8'h20, 8'h30));
        send_pixel(mk_pixel(12'hFFF, 12'hFFF, 16'd0, 8'hFF, 8'hFF, 8'hFF));
        send_corners();
    endtask

    task automatic test_field_extremes();
        load_coefs(COEF_CAMERA);
        send_corners();
        send_pixel(mk_pixel(12'hFFF, 12'hFFF, 16'd0, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(mk_pixel(12'd1, 12'd1, 16'd2, 8'h01, 8'h80, 8'hFE));
    endtask

    task automatic test_saturation();
        load_coefs(COEF_MAX);
        send_corners();
        load_coefs(COEF_MIN);
        send_corners();
        load_coefs(COEF_ONES);
        send_corners();
    endtask

    // Half-way values must round toward plus infinity on both signs.
    task automatic test_rounding_ties();
        write_all(64'd0, {32'sd0, 32'sd128}, 64'd0, {32'sd0, -32'sd128},
                  64'd0, {32'sd0, -32'sd384});
        send_pixel(mk_pixel(12'd7, 12'd9, 16'd1, 8'h11, 8'h22, 8'h33));
        write_all(64'd0, {32'sd128000, 32'sd0}, 64'd0, {-32'sd128000, 32'sd0},
                  64'd0, {32'sd1, 32'sd0});
        send_pixel(mk_pixel(12'd0, 12'd0, 16'd1, 8'h44, 8'h55, 8'h66));
        send_pixel(mk_pixel(12'd0, 12'd0, 16'd3, 8'h77, 8'h88, 8'h99));
        send_pixel(mk_pixel(12'd0, 12'd0, 16'hFFFF, 8'hAA, 8'hBB, 8'hCC));
    endtask

    task automatic test_spare_index();
        load_coefs(COEF_CAMERA);
        write_reg(CFG_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_SPARE_HI, {$urandom, $urandom});
        send_corners();
    endtask

    task automatic run_phase(t_coef_style style, int points, bit tx_gaps, bit rx_stalls,
                             int pause_at);
        t_pixel px;
        int sent;
        load_coefs(style);
        tx_gaps_on = tx_gaps;
        rx_stalls_on = rx_stalls;
        sent = 0;
        while (sent < points) begin
            px = rand_pixel();
            send_pixel(px);
            if (px.depth_mm != 16'd0)
                sent++;
            // hold the sender until every point is out
            if (sent == pause_at && px.depth_mm != 16'd0)
                drain_points();
        end
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_phase(COEF_CAMERA, 400, 1'b1, 1'b1, -1);
        run_phase(COEF_CAMERA, 400, 1'b0, 1'b0, -1);
        run_phase(COEF_RANDOM, 300, 1'b1, 1'b1, 150);
        run_phase(COEF_CAMERA, 300, 1'b0, 1'b1, -1);
        run_phase(COEF_MAX, 100, 1'b1, 1'b0, -1);
        run_phase(COEF_MIN, 100, 1'b1, 1'b1, -1);
        run_phase(COEF_CAMERA, 200, 1'b1, 1'b1, 100);
    endtask

    // Result side: pop, with random stalls while rx_stalls_on is set.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                pop <= 1'b0;
                rx_hold--;
            end else begin
                pop <= 1'b1;
                if (rx_stalls_on)
                    rx_hold = rand_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_point
        t_point want;
        if (i_rst_n && pop && !empty) begin
            if (pending_points.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: point with none expected, actual %h", $time, o_point);
            end else begin
                want = pending_points.pop_front();
                check_field("point_x", want.point_x, o_point.point_x);
                check_field("point_y", want.point_y, o_point.point_y);
                check_field("point_z", want.point_z, o_point.point_z);
                check_field("out_red", 32'(want.out_red), 32'(o_point.out_red));
                check_field("out_green", 32'(want.out_green), 32'(o_point.out_green));
                check_field("out_blue", 32'(want.out_blue), 32'(o_point.out_blue));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("** depth_pixel_backprojection: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_pixel     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        foreach (coef_regs[i])
            coef_regs[i] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_saturation();
        test_rounding_ties();
        test_spare_index();
        test_random_traffic();

        settle();
        if (mismatch_cnt == 0)
            $display("** depth_pixel_backprojection: PASSED **");
        else
            $display("** depth_pixel_backprojection: FAILED **");
        $finish;
    end

endmodule
